/* design/msp_pkg.sv */
package msp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PREV   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_FIRST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_SECOND  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_SCALE   = 3'd6;

	localparam logic [23:0] RST_GAIN_NOW    = 24'd118907;
	localparam logic [23:0] RST_GAIN_PREV   = 24'd77852;
	localparam logic [14:0] RST_REF_FIRST   = 15'd144;
	localparam logic [14:0] RST_REF_SECOND  = 15'd288;
	localparam logic [7:0]  RST_HALF_PERIOD = 8'd100;
	localparam logic [15:0] RST_SPIKE_LIMIT = 16'd7200;
	localparam logic [15:0] RST_PWM_SCALE   = 16'd1000;

	localparam int DUTY_W = 16;
	localparam int VEL_W  = 17;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} front_ctl_t;

	typedef struct packed {
		logic led;
		logic spike;
	} front_stat_t;

endpackage

/* design/msp_if.sv */
interface msp_sample_if #(parameter int ENC_W = 16);
	logic                    valid;
	logic                    ready;
	logic signed [ENC_W-1:0] encoder_count;

	modport source (output valid, output encoder_count, input ready);
	modport sink   (input valid, input encoder_count, output ready);
endinterface

interface msp_drive_if;
	logic               valid;
	logic               ready;
	logic [15:0]        duty_forward;
	logic [15:0]        duty_reverse;
	logic               led_on;
	logic               spike_seen;
	logic signed [16:0] velocity_counts;

	modport source (output valid, output duty_forward, output duty_reverse, output led_on,
		output spike_seen, output velocity_counts, input ready);
	modport sink   (input valid, input duty_forward, input duty_reverse, input led_on,
		input spike_seen, input velocity_counts, output ready);
endinterface

/* design/msp_front.sv */
module msp_front
	import msp_pkg::*;
#(
	parameter int ENC_W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  front_ctl_t              ctl,
	input  logic signed [ENC_W-1:0] count,
	input  logic [14:0]             ref_first,
	input  logic [14:0]             ref_second,
	input  logic [7:0]              half_period,
	input  logic [15:0]             spike_limit,
	output logic signed [ENC_W:0]   vel,
	output logic signed [((ENC_W+1 > 16) ? ENC_W+1 : 16):0] err,
	output logic signed [((ENC_W+1 > 16) ? ENC_W+1 : 16):0] last_err,
	output front_stat_t             stat
);

	localparam int VW = ENC_W + 1;
	localparam int CW = (VW > 16) ? VW : 16;
	localparam int EW = CW + 1;

	logic signed [ENC_W-1:0] count_q;
	logic signed [ENC_W-1:0] last_count_q;
	logic signed [VW-1:0]    vel_q;
	logic signed [EW-1:0]    err_q;
	logic signed [EW-1:0]    last_err_q;
	logic [7:0]              phase_q;
	logic                    led_q;
	logic                    spike_q;

	logic signed [VW-1:0] diff;
	logic [VW-1:0]        mag;
	logic                 reject;
	logic signed [VW-1:0] vel_new;
	logic                 first_half;
	logic [14:0]          ref_sel;
	logic [8:0]           phase_inc;

	assign diff       = VW'(count_q) - VW'(last_count_q);
	assign mag        = diff[VW-1] ? VW'(-diff) : VW'(diff);
	assign reject     = CW'(mag) >= CW'(spike_limit);
	assign vel_new    = reject ? vel_q : diff;
	assign first_half = phase_q < half_period;
	assign ref_sel    = first_half ? ref_first : ref_second;
	assign phase_inc  = 9'(phase_q) + 9'd1;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			count_q <= count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
			vel_q        <= '0;
			err_q        <= '0;
			last_err_q   <= '0;
			phase_q      <= '0;
			led_q        <= 1'b0;
			spike_q      <= 1'b0;
		end else begin
			if (ctl.step) begin
				last_count_q <= count_q;
				vel_q        <= vel_new;
				err_q        <= $signed(EW'(ref_sel)) - EW'(vel_new);
				led_q        <= first_half;
				spike_q      <= spike_q | reject;
				phase_q      <= (phase_inc >= {half_period, 1'b0}) ? 8'd0 : phase_inc[7:0];
			end
			if (ctl.commit) begin
				last_err_q <= err_q;
			end
		end
	end

	assign vel        = vel_q;
	assign err        = err_q;
	assign last_err   = last_err_q;
	assign stat.led   = led_q;
	assign stat.spike = spike_q;

endmodule

/* design/msp_mult.sv */
module msp_mult #(
	parameter int A_W = 25,
	parameter int B_W = 18
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] prod
);

	logic signed [A_W+B_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

	assign prod = prod_q;

endmodule

/* design/motor_speed_pi_controller_unit.sv */
// An input tick passes the states PREP, M1, M2, ACC and M3, and in OUT the
// result is loaded once the output register is free; one shared multiplier
// is used three times per tick (two gain products, then the PWM scaling).
// The input stays not ready from the transfer until the result is loaded.
// Reset (arst_n low, asynchronous) clears the controller state and loads the
// register defaults; it takes effect at once and needs no clearing pass.
module motor_speed_pi_controller_unit
	import msp_pkg::*;
#(
	parameter int ENCODER_BITS   = 16,
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	msp_sample_if.sink            sample,
	msp_drive_if.source           drive,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int F  = GAIN_FRAC_BITS;
	localparam int VW = ENCODER_BITS + 1;
	localparam int CW = (VW > 16) ? VW : 16;
	localparam int EW = CW + 1;
	localparam int MA = (F + 2 > 25) ? F + 2 : 25;
	localparam int MB = EW;
	localparam int PW = MA + MB;
	localparam int AW = PW + 2;
	localparam int DW = F + 2;
	localparam logic signed [AW-1:0] U_ONE = AW'(64'd1 << F);
	localparam logic signed [AW-1:0] U_NEG = -U_ONE;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_M1   = 3'd2;
	localparam logic [2:0] S_M2   = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;
	localparam logic [2:0] S_M3   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]  state_q;
	logic [23:0] gain_now_q;
	logic [23:0] gain_prev_q;
	logic [14:0] ref_first_q;
	logic [14:0] ref_second_q;
	logic [7:0]  half_period_q;
	logic [15:0] spike_limit_q;
	logic [15:0] pwm_scale_q;

	logic signed [AW-1:0] acc_q;
	logic signed [DW-1:0] drive_q;
	logic [F:0]           umag_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [15:0]          duty_fwd_q;
	logic [15:0]          duty_rev_q;
	logic                 led_q;
	logic                 spike_q;
	logic signed [16:0]   vel_out_q;

	front_ctl_t           fctl;
	front_stat_t          fstat;
	logic signed [VW-1:0] vel;
	logic signed [EW-1:0] err;
	logic signed [EW-1:0] last_err;
	logic signed [EW-1:0] vel_ext;

	logic                 mul_en;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] prod;

	logic signed [AW-1:0] u_sum;
	logic signed [AW-1:0] u_clamp;
	logic signed [AW-1:0] u_abs;
	logic                 accept;
	logic                 load_out;

	assign accept   = sample.valid && sample.ready;
	assign load_out = (state_q == S_OUT) && (!out_valid_q || drive.ready);

	assign sample.ready = (state_q == S_IDLE);

	assign fctl.load   = accept;
	assign fctl.step   = (state_q == S_PREP);
	assign fctl.commit = (state_q == S_ACC);

	msp_front #(.ENC_W(ENCODER_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fctl),
		.count      (sample.encoder_count),
		.ref_first  (ref_first_q),
		.ref_second (ref_second_q),
		.half_period(half_period_q),
		.spike_limit(spike_limit_q),
		.vel        (vel),
		.err        (err),
		.last_err   (last_err),
		.stat       (fstat)
	);

	always_comb begin
		mul_en = 1'b0;
		mul_a  = $signed(MA'(gain_now_q));
		mul_b  = MB'(err);
		case (state_q)
			S_M1: begin
				mul_en = 1'b1;
			end
			S_M2: begin
				mul_en = 1'b1;
				mul_a  = $signed(MA'(gain_prev_q));
				mul_b  = MB'(last_err);
			end
			S_M3: begin
				mul_en = 1'b1;
				mul_a  = $signed(MA'(umag_q));
				mul_b  = $signed(MB'(pwm_scale_q));
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	msp_mult #(.A_W(MA), .B_W(MB)) u_mult (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	assign u_sum   = acc_q - AW'(prod);
	assign u_clamp = (u_sum > U_ONE) ? U_ONE : ((u_sum < U_NEG) ? U_NEG : u_sum);
	assign u_abs   = u_clamp[AW-1] ? -u_clamp : u_clamp;
	assign vel_ext = EW'(vel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_now_q    <= RST_GAIN_NOW;
			gain_prev_q   <= RST_GAIN_PREV;
			ref_first_q   <= RST_REF_FIRST;
			ref_second_q  <= RST_REF_SECOND;
			half_period_q <= RST_HALF_PERIOD;
			spike_limit_q <= RST_SPIKE_LIMIT;
			pwm_scale_q   <= RST_PWM_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_NOW:    gain_now_q    <= cfg_data[23:0];
				CFG_GAIN_PREV:   gain_prev_q   <= cfg_data[23:0];
				CFG_REF_FIRST:   ref_first_q   <= cfg_data[14:0];
				CFG_REF_SECOND:  ref_second_q  <= cfg_data[14:0];
				CFG_HALF_PERIOD: half_period_q <= cfg_data[7:0];
				CFG_SPIKE_LIMIT: spike_limit_q <= cfg_data[15:0];
				CFG_PWM_SCALE:   pwm_scale_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			drive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_PREP;
				S_PREP: state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_ACC;
				S_ACC: begin
					drive_q <= u_clamp[DW-1:0];
					state_q <= S_M3;
				end
				S_M3:   state_q <= S_OUT;
				S_OUT:  if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_M2) begin
			acc_q <= AW'(prod) + AW'(drive_q);
		end
		if (state_q == S_ACC) begin
			neg_q  <= u_clamp[AW-1];
			umag_q <= u_abs[F:0];
		end
		if (load_out) begin
			duty_fwd_q <= neg_q ? 16'd0 : prod[F+DUTY_W-1:F];
			duty_rev_q <= neg_q ? prod[F+DUTY_W-1:F] : 16'd0;
			led_q      <= fstat.led;
			spike_q    <= fstat.spike;
			vel_out_q  <= vel_ext[VEL_W-1:0];
		end
	end

	assign drive.valid           = out_valid_q;
	assign drive.duty_forward    = duty_fwd_q;
	assign drive.duty_reverse    = duty_rev_q;
	assign drive.led_on          = led_q;
	assign drive.spike_seen      = spike_q;
	assign drive.velocity_counts = vel_out_q;

endmodule

/* design/msp_checker.sv */
module msp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] duty_fwd,
	input logic [15:0] duty_rev,
	input logic        spike_seen
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && out_ready && spike_seen) begin
			seen_q <= 1'b1;
		end
	end

	// one tick in flight at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// only one direction driven
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_fwd == 16'd0 || duty_rev == 16'd0))
		else $error("forward and reverse duty both nonzero");

	a_spike_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> spike_seen)
		else $error("spike flag cleared");

endmodule

bind motor_speed_pi_controller_unit msp_checker u_msp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (drive.valid),
	.out_ready (drive.ready),
	.duty_fwd  (drive.duty_forward),
	.duty_rev  (drive.duty_reverse),
	.spike_seen(drive.spike_seen)
);
